// ===== hdl/fsts_pkg.sv =====
`timescale 1ns / 1ps

package fsts_pkg;

   // Table geometry.
   localparam int MAX_TASKS = 32;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int TC_W      = $clog2(MAX_TASKS + 2);

   // Field widths.
   localparam int VR_W    = 48;
   localparam int PID_W   = 16;
   localparam int PRIO_W  = 3;
   localparam int SLICE_W = 8;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [SLICE_W-1:0] INIT_SLICE = 8'd20;
   localparam logic [PRIO_W-1:0]  MAX_PRIO   = 3'd5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_NONE    = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_BASE   = 1'b1;

   // Token that walks the cell chain: best entry so far and first free slot.
   typedef struct packed {
      logic                found;
      logic [VR_W-1:0]     vr;
      logic [PID_W-1:0]    pid;
      logic [PRIO_W-1:0]   prio;
      logic [SLICE_W-1:0]  slice;
      logic [IDX_W-1:0]    idx;
      logic                free_found;
      logic [IDX_W-1:0]    free_idx;
   } cand_type;

   // Write broadcast from the controller to the cells.
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    idx;
      logic                valid;
      logic [VR_W-1:0]     vr;
      logic [PID_W-1:0]    pid;
      logic [PRIO_W-1:0]   prio;
      logic [SLICE_W-1:0]  slice;
   } wr_type;

endpackage

// ===== hdl/fair_share_task_scheduler_top.sv =====
`timescale 1ns / 1ps

// Fair-share scheduler for one CPU.
// Request beats on req_* carry a command (tick, schedule, add, yield, exit),
// a priority and a start virtual runtime; each request gives exactly one
// response beat on rsp_* with the running task, flags, the assigned pid and
// a status. csr_* writes sched_enable (index 0) and base_slice (index 1);
// the user writes them only while the block is idle; the block does not enforce this.
// Waiting tasks sit in a row of cells; a search token moves one cell per
// cycle, and schedule and add wait until it has passed the last cell.
// A tick that refills the slice runs an 8-step divider; other commands go
// from request beat to response beat through the decode and reply states.
// One request is worked on at a time; req_tready is low while a request is
// in progress or a response beat waits.
// Reset clears the table, makes pid 0 the running task with a slice of 20,
// and disables scheduling. A stalled rsp_tready holds the response beat and
// keeps req_tready low until it is taken.
module fair_share_task_scheduler_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], new_priority[5:3], start_vruntime[53:6]
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // running_pid[15:0], running_vruntime[63:16], need_resched[64],
   // switched[65], assigned_pid[81:66], status[83:82]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_wr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_REPLY  = 3'd4;

   localparam int VR_W    = fsts_pkg::VR_W;
   localparam int PID_W   = fsts_pkg::PID_W;
   localparam int PRIO_W  = fsts_pkg::PRIO_W;
   localparam int SLICE_W = fsts_pkg::SLICE_W;
   localparam int TC_W    = fsts_pkg::TC_W;
   localparam int CNT_W   = fsts_pkg::CNT_W;

   logic [2:0]                  state_ff, state_in;
   logic [fsts_pkg::CMD_W-1:0]  cmd_ff;
   logic [PRIO_W-1:0]           prio_ff;
   logic [VR_W-1:0]             svr_ff;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [PID_W-1:0]            run_pid_ff, run_pid_in;
   logic [VR_W-1:0]             run_vr_ff, run_vr_in;
   logic [PRIO_W-1:0]           run_prio_ff, run_prio_in;
   logic [SLICE_W-1:0]          run_slice_ff, run_slice_in;
   logic                        run_valid_ff, run_valid_in;
   logic                        run_need_ff, run_need_in;
   logic                        run_killed_ff, run_killed_in;
   logic [TC_W-1:0]             task_count_ff, task_count_in;
   logic [PID_W-1:0]            next_pid_ff, next_pid_in;
   logic                        en_ff;
   logic [SLICE_W-1:0]          base_ff;
   logic                        sw_ff, sw_in;
   logic [PID_W-1:0]            assigned_ff, assigned_in;
   logic [fsts_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        rsp_valid_ff;
   logic [87:0]                 rsp_data_ff;

   logic                        req_fire;
   logic                        div_start;
   logic                        div_done;
   logic [SLICE_W-1:0]          div_q;
   logic [TC_W-1:0]             divisor;
   logic [PRIO_W-1:0]           weight;
   logic [SLICE_W-1:0]          q_min1;
   logic [10:0]                 refill;
   logic                        keep;
   logic                        tail_less;
   fsts_pkg::wr_type            wr;
   fsts_pkg::cand_type          chain [fsts_pkg::MAX_TASKS+1];

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // Cell chain: an empty token enters the first cell every cycle.
   always_comb begin
      chain[0] = '0;
   end

   for (genvar g = 0; g < fsts_pkg::MAX_TASKS; g++) begin : g_cell
      fsts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (fsts_pkg::IDX_W'(g)),
         .cand_in    (chain[g]),
         .cand_out   (chain[g+1]),
         .wr         (wr)
      );
   end

   // Slice refill divider.
   assign divisor = (task_count_ff == '0) ? TC_W'(1) : task_count_ff;

   fsts_slice_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (base_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign weight = run_prio_ff + 1'b1;
   assign q_min1 = (div_q == '0) ? SLICE_W'(1) : div_q;
   assign refill = 11'(weight) * 11'(q_min1);
   assign keep   = run_valid_ff && !run_killed_ff;
   assign tail_less = (chain[fsts_pkg::MAX_TASKS].vr < run_vr_ff) ||
                      ((chain[fsts_pkg::MAX_TASKS].vr == run_vr_ff) &&
                       (chain[fsts_pkg::MAX_TASKS].pid < run_pid_ff));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b0;
         base_ff <= fsts_pkg::INIT_SLICE;
      end else if (csr_wr_en) begin
         case (csr_index)
            fsts_pkg::CSR_ENABLE: en_ff   <= csr_wr_data[0];
            fsts_pkg::CSR_BASE:   base_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      run_pid_in    = run_pid_ff;
      run_vr_in     = run_vr_ff;
      run_prio_in   = run_prio_ff;
      run_slice_in  = run_slice_ff;
      run_valid_in  = run_valid_ff;
      run_need_in   = run_need_ff;
      run_killed_in = run_killed_ff;
      task_count_in = task_count_ff;
      next_pid_in   = next_pid_ff;
      sw_in         = sw_ff;
      assigned_in   = assigned_ff;
      status_in     = status_ff;
      div_start     = 1'b0;
      wr            = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in    = S_DECODE;
               sw_in       = 1'b0;
               assigned_in = '0;
               status_in   = fsts_pkg::ST_IGNORED;
            end
         end
         S_DECODE: begin
            state_in = S_REPLY;
            case (cmd_ff)
               fsts_pkg::CMD_TICK: begin
                  if (en_ff && run_valid_ff) begin
                     status_in = fsts_pkg::ST_OK;
                     run_vr_in = run_vr_ff + VR_W'(weight);
                     if (run_slice_ff <= SLICE_W'(weight)) begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end else begin
                        run_slice_in = run_slice_ff - SLICE_W'(weight);
                        run_need_in  = 1'b0;
                     end
                  end
               end
               fsts_pkg::CMD_SCHEDULE: begin
                  if (en_ff && run_need_ff) begin
                     cnt_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               fsts_pkg::CMD_ADD: begin
                  cnt_in   = '0;
                  state_in = S_SCAN;
               end
               fsts_pkg::CMD_YIELD, fsts_pkg::CMD_EXIT: begin
                  if (run_valid_ff) begin
                     run_need_in  = 1'b1;
                     run_slice_in = '0;
                     status_in    = fsts_pkg::ST_OK;
                     if (cmd_ff == fsts_pkg::CMD_EXIT) begin
                        run_killed_in = 1'b1;
                     end
                  end else begin
                     status_in = fsts_pkg::ST_NONE;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               run_need_in  = 1'b1;
               run_slice_in = (refill > 11'd255) ? 8'd255 : refill[SLICE_W-1:0];
               state_in     = S_REPLY;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(fsts_pkg::MAX_TASKS)) begin
               cnt_in   = cnt_ff;
               state_in = S_REPLY;
               if (cmd_ff == fsts_pkg::CMD_ADD) begin
                  if (chain[fsts_pkg::MAX_TASKS].free_found) begin
                     wr.en         = 1'b1;
                     wr.idx        = chain[fsts_pkg::MAX_TASKS].free_idx;
                     wr.valid      = 1'b1;
                     wr.vr         = svr_ff;
                     wr.pid        = next_pid_ff;
                     wr.prio       = (prio_ff > fsts_pkg::MAX_PRIO) ? fsts_pkg::MAX_PRIO
                                                                     : prio_ff;
                     wr.slice      = fsts_pkg::INIT_SLICE;
                     assigned_in   = next_pid_ff;
                     next_pid_in   = next_pid_ff + 1'b1;
                     task_count_in = task_count_ff + 1'b1;
                     status_in     = fsts_pkg::ST_OK;
                  end else begin
                     status_in = fsts_pkg::ST_FULL;
                  end
               end else begin
                  run_need_in = 1'b0;
                  if (run_valid_ff && run_killed_ff) begin
                     run_valid_in  = 1'b0;
                     run_killed_in = 1'b0;
                     if (task_count_ff != '0) begin
                        task_count_in = task_count_ff - 1'b1;
                     end
                  end
                  if (!chain[fsts_pkg::MAX_TASKS].found) begin
                     status_in = keep ? fsts_pkg::ST_OK : fsts_pkg::ST_NONE;
                  end else if (keep && !tail_less) begin
                     status_in = fsts_pkg::ST_OK;
                  end else begin
                     // Swap the winner out of the table; a live runner takes its slot.
                     wr.en         = 1'b1;
                     wr.idx        = chain[fsts_pkg::MAX_TASKS].idx;
                     wr.valid      = keep;
                     wr.vr         = run_vr_ff;
                     wr.pid        = run_pid_ff;
                     wr.prio       = run_prio_ff;
                     wr.slice      = run_slice_ff;
                     run_pid_in    = chain[fsts_pkg::MAX_TASKS].pid;
                     run_vr_in     = chain[fsts_pkg::MAX_TASKS].vr;
                     run_prio_in   = chain[fsts_pkg::MAX_TASKS].prio;
                     run_slice_in  = chain[fsts_pkg::MAX_TASKS].slice;
                     run_valid_in  = 1'b1;
                     run_killed_in = 1'b0;
                     sw_in         = 1'b1;
                     status_in     = fsts_pkg::ST_OK;
                  end
               end
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         run_pid_ff    <= '0;
         run_vr_ff     <= '0;
         run_prio_ff   <= '0;
         run_slice_ff  <= fsts_pkg::INIT_SLICE;
         run_valid_ff  <= 1'b1;
         run_need_ff   <= 1'b0;
         run_killed_ff <= 1'b0;
         task_count_ff <= TC_W'(1);
         next_pid_ff   <= PID_W'(1);
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         run_pid_ff    <= run_pid_in;
         run_vr_ff     <= run_vr_in;
         run_prio_ff   <= run_prio_in;
         run_slice_ff  <= run_slice_in;
         run_valid_ff  <= run_valid_in;
         run_need_ff   <= run_need_in;
         run_killed_ff <= run_killed_in;
         task_count_ff <= task_count_in;
         next_pid_ff   <= next_pid_in;
      end
   end

   // Request and per-item result registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_tdata[2:0];
         prio_ff <= req_tdata[5:3];
         svr_ff  <= req_tdata[53:6];
      end
      sw_ff       <= sw_in;
      assigned_ff <= assigned_in;
      status_ff   <= status_in;
   end

   // Response beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_REPLY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_REPLY) begin
         rsp_data_ff <= {4'd0, status_ff, assigned_ff, sw_ff, run_need_ff,
                         run_valid_ff ? run_vr_ff : {VR_W{1'b0}},
                         run_valid_ff ? run_pid_ff : {PID_W{1'b0}}};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_DECODE) else $error("accepted beat not decoded");
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && sw_ff) |-> status_ff == fsts_pkg::ST_OK)
      else $error("switch with bad status");
   a_assign_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && assigned_ff != '0) |-> status_ff == fsts_pkg::ST_OK)
      else $error("pid assigned with bad status");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      task_count_ff <= TC_W'(fsts_pkg::MAX_TASKS + 1)) else $error("task count overflow");
`endif

endmodule

// ===== hdl/fsts_cell.sv =====
`timescale 1ns / 1ps

module fsts_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fsts_pkg::IDX_W-1:0]     cell_index,
   input  fsts_pkg::cand_type             cand_in,
   output fsts_pkg::cand_type             cand_out,
   input  fsts_pkg::wr_type               wr
);

   logic                              valid_ff;
   logic [fsts_pkg::VR_W-1:0]         vr_ff;
   logic [fsts_pkg::PID_W-1:0]        pid_ff;
   logic [fsts_pkg::PRIO_W-1:0]       prio_ff;
   logic [fsts_pkg::SLICE_W-1:0]      slice_ff;
   fsts_pkg::cand_type                cand_ff;
   fsts_pkg::cand_type                cand_in_next;
   logic                              better;

   // This entry beats the token when it is valid and the token is empty or holds a larger (vr, pid).
   assign better = valid_ff && (!cand_in.found || (vr_ff < cand_in.vr) ||
                   ((vr_ff == cand_in.vr) && (pid_ff < cand_in.pid)));

   always_comb begin
      cand_in_next = cand_in;
      if (better) begin
         cand_in_next.found = 1'b1;
         cand_in_next.vr    = vr_ff;
         cand_in_next.pid   = pid_ff;
         cand_in_next.prio  = prio_ff;
         cand_in_next.slice = slice_ff;
         cand_in_next.idx   = cell_index;
      end
      if (!valid_ff && !cand_in.free_found) begin
         cand_in_next.free_found = 1'b1;
         cand_in_next.free_idx   = cell_index;
      end
   end

   // The token moves one cell per cycle.
   always_ff @(posedge clock) begin
      cand_ff <= cand_in_next;
   end

   assign cand_out = cand_ff;

   // Entry storage, written by the controller broadcast.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && (wr.idx == cell_index)) begin
         valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_index)) begin
         vr_ff    <= wr.vr;
         pid_ff   <= wr.pid;
         prio_ff  <= wr.prio;
         slice_ff <= wr.slice;
      end
   end

endmodule

// ===== hdl/fsts_slice_div.sv =====
`timescale 1ns / 1ps

module fsts_slice_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsts_pkg::SLICE_W-1:0]    dividend,
   input  logic [fsts_pkg::TC_W-1:0]       divisor,
   output logic                            done,
   output logic [fsts_pkg::SLICE_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(fsts_pkg::SLICE_W + 1);

   logic [fsts_pkg::TC_W-1:0]     rem_ff;
   logic [fsts_pkg::SLICE_W-1:0]  quot_ff;
   logic [fsts_pkg::TC_W-1:0]     div_ff;
   logic [STEP_W-1:0]             step_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [fsts_pkg::TC_W:0]       trial;
   logic                          ge;

   // One restoring step per cycle, most significant bit first.
   assign trial = {rem_ff, quot_ff[fsts_pkg::SLICE_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(fsts_pkg::SLICE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= ge ? fsts_pkg::TC_W'(trial - {1'b0, div_ff})
                       : fsts_pkg::TC_W'(trial);
         quot_ff <= {quot_ff[fsts_pkg::SLICE_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff) else $error("divider remainder too large");
`endif

endmodule
